FILE: sv/bzs_pkg.sv
package bzs_pkg;

  localparam int unsigned CountW = 4;
  localparam int unsigned AccW   = 52;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic signed [31:0] lead_tangent_x;
    logic signed [31:0] lead_tangent_y;
    logic signed [31:0] lead_tangent_z;
    logic signed [31:0] trail_tangent_x;
    logic signed [31:0] trail_tangent_y;
    logic signed [31:0] trail_tangent_z;
  } seg_req_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [2:0]         point_number;
    logic               last_point;
  } point_rsp_t;

  typedef struct packed {
    logic       clear;
    logic [1:0] term;
  } mac_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_EMIT
  } state_e;

endpackage

FILE: sv/bezier_segment_subdivider.sv
// Each point is computed by one shared multiply-accumulate unit, 4 terms x 3 axes in turn,
// then registered and presented; a segment count of N yields N-1 points per segment.
// One segment at a time through the shared MAC; not ready until its last point has been taken.
// Reset: asynchronous active low; segment count returns to 2, the sequencer to idle.
module bezier_segment_subdivider #(
  parameter int MAX_SEGMENTS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  bzs_pkg::seg_req_t         in_req_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output bzs_pkg::point_rsp_t       out_rsp_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [bzs_pkg::CountW-1:0] cfg_data_i
);

  localparam int MaxCount = 2 ** bzs_pkg::CountW - 1;
  localparam logic [bzs_pkg::CountW-1:0] MaxN =
    bzs_pkg::CountW'((MAX_SEGMENTS > MaxCount) ? MaxCount : MAX_SEGMENTS);

  bzs_pkg::state_e state_q, state_d;
  logic [bzs_pkg::CountW-1:0] count_q, n_q, n_eff, idx_q, idx_d;
  logic [1:0] axis_q, axis_d, term_q, term_d;
  logic signed [32:0] pt_q [3][4];
  logic signed [bzs_pkg::AccW-1:0] acc_q, acc_d;
  logic signed [31:0] res_q [3];
  logic signed [31:0] rounded;
  logic [15:0] weight;
  bzs_pkg::point_rsp_t rsp_q;
  bzs_pkg::mac_ctrl_t ctrl;
  logic accept, finish_axis, out_load;

  assign cfg_ready_o = 1'b1;
  assign n_eff = (count_q > MaxN) ? MaxN : count_q;
  assign in_ready_o = (state_q == bzs_pkg::ST_IDLE);
  assign accept = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == bzs_pkg::ST_EMIT);
  assign out_rsp_o = rsp_q;
  assign ctrl.clear = (term_q == 2'd0);
  assign ctrl.term = term_q;

  bzs_weight_rom u_rom (
    .n_i      (n_q),
    .idx_i    (idx_q),
    .term_i   (ctrl.term),
    .weight_o (weight)
  );

  bzs_mac u_mac (
    .operand_i (pt_q[axis_q][ctrl.term]),
    .weight_i  (weight),
    .clear_i   (ctrl.clear),
    .acc_i     (acc_q),
    .acc_o     (acc_d),
    .rounded_o (rounded)
  );

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    axis_d = axis_q;
    term_d = term_q;
    finish_axis = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      bzs_pkg::ST_IDLE: begin
        if (accept && n_eff >= 2) begin
          state_d = bzs_pkg::ST_MAC;
          idx_d = bzs_pkg::CountW'(1);
          axis_d = '0;
          term_d = '0;
        end
      end
      bzs_pkg::ST_MAC: begin
        term_d = term_q + 2'd1;
        if (term_q == 2'd3) begin
          finish_axis = 1'b1;
          if (axis_q == 2'd2) begin
            axis_d = '0;
            out_load = 1'b1;
            state_d = bzs_pkg::ST_EMIT;
          end else begin
            axis_d = axis_q + 2'd1;
          end
        end
      end
      bzs_pkg::ST_EMIT: begin
        if (out_ready_i) begin
          if (idx_q == n_q - 1'b1) begin
            state_d = bzs_pkg::ST_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
            state_d = bzs_pkg::ST_MAC;
          end
        end
      end
      default: state_d = bzs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bzs_pkg::ST_IDLE;
      count_q <= 4'd2;
      idx_q <= '0;
      axis_q <= '0;
      term_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      axis_q <= axis_d;
      term_q <= term_d;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      n_q <= n_eff;
      pt_q[0][0] <= 33'(in_req_i.start_x);
      pt_q[1][0] <= 33'(in_req_i.start_y);
      pt_q[2][0] <= 33'(in_req_i.start_z);
      pt_q[0][3] <= 33'(in_req_i.end_x);
      pt_q[1][3] <= 33'(in_req_i.end_y);
      pt_q[2][3] <= 33'(in_req_i.end_z);
      pt_q[0][1] <= 33'(in_req_i.start_x) + 33'(in_req_i.lead_tangent_x);
      pt_q[1][1] <= 33'(in_req_i.start_y) + 33'(in_req_i.lead_tangent_y);
      pt_q[2][1] <= 33'(in_req_i.start_z) + 33'(in_req_i.lead_tangent_z);
      pt_q[0][2] <= 33'(in_req_i.end_x) - 33'(in_req_i.trail_tangent_x);
      pt_q[1][2] <= 33'(in_req_i.end_y) - 33'(in_req_i.trail_tangent_y);
      pt_q[2][2] <= 33'(in_req_i.end_z) - 33'(in_req_i.trail_tangent_z);
    end
    if (state_q == bzs_pkg::ST_MAC) begin
      acc_q <= acc_d;
    end
    if (finish_axis) begin
      res_q[axis_q] <= rounded;
    end
    if (out_load) begin
      rsp_q.point_x <= res_q[0];
      rsp_q.point_y <= res_q[1];
      rsp_q.point_z <= rounded;
      rsp_q.point_number <= idx_q[2:0];
      rsp_q.last_point <= (idx_q == n_q - 1'b1);
    end
  end

endmodule

FILE: sv/bzs_weight_rom.sv
module bzs_weight_rom (
  input  logic [bzs_pkg::CountW-1:0] n_i,
  input  logic [bzs_pkg::CountW-1:0] idx_i,
  input  logic [1:0]                 term_i,
  output logic [15:0]                weight_o
);

  localparam int unsigned Span = 2 ** bzs_pkg::CountW;

  logic [15:0] tbl [Span*Span][4];

  for (genvar gn = 0; gn < Span; gn++) begin : g_n
    for (genvar gi = 0; gi < Span; gi++) begin : g_i
      if (gn >= 2 && gi >= 1 && gi < gn) begin : g_val
        localparam int Den = gn * gn * gn;
        localparam int U   = gn - gi;
        localparam int W0  = (U * U * U * 65536 + Den / 2) / Den;
        localparam int W1  = (3 * gi * U * U * 65536 + Den / 2) / Den;
        localparam int W2  = (3 * gi * gi * U * 65536 + Den / 2) / Den;
        localparam int W3  = (gi * gi * gi * 65536 + Den / 2) / Den;
        assign tbl[gn*Span+gi][0] = 16'(W0);
        assign tbl[gn*Span+gi][1] = 16'(W1);
        assign tbl[gn*Span+gi][2] = 16'(W2);
        assign tbl[gn*Span+gi][3] = 16'(W3);
      end else begin : g_zero
        for (genvar gk = 0; gk < 4; gk++) begin : g_k
          assign tbl[gn*Span+gi][gk] = '0;
        end
      end
    end
  end

  assign weight_o = tbl[{n_i, idx_i}][term_i];

endmodule

FILE: sv/bzs_mac.sv
module bzs_mac (
  input  logic signed [32:0]               operand_i,
  input  logic [15:0]                      weight_i,
  input  logic                             clear_i,
  input  logic signed [bzs_pkg::AccW-1:0]  acc_i,
  output logic signed [bzs_pkg::AccW-1:0]  acc_o,
  output logic signed [31:0]               rounded_o
);

  logic signed [49:0] prod;
  logic signed [bzs_pkg::AccW-1:0] base;
  logic signed [bzs_pkg::AccW-1:0] biased;
  logic signed [bzs_pkg::AccW-17:0] shifted;

  assign prod   = operand_i * $signed({1'b0, weight_i});
  assign base   = clear_i ? '0 : acc_i;
  assign acc_o  = base + bzs_pkg::AccW'(prod);
  assign biased = acc_o + bzs_pkg::AccW'(32768);
  assign shifted = biased[bzs_pkg::AccW-1:16];

  always_comb begin
    if (shifted > $signed(36'sh07FFFFFFF)) begin
      rounded_o = 32'sh7FFFFFFF;
    end else if (shifted < $signed(-36'sh080000000)) begin
      rounded_o = 32'sh80000000;
    end else begin
      rounded_o = shifted[31:0];
    end
  end

endmodule
